/* rtl/core/rmcu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rmcu_pkg;

	localparam int DIM     = 4;
	localparam int CNT_W   = 16;
	localparam int QW      = 48;
	localparam int FRAC    = 32;
	localparam int MAG_W   = 49;
	localparam int NUM_W   = 80;
	localparam int RAD_W   = 96;
	localparam int PROD_W  = 98;
	localparam int ACC_W   = 100;
	localparam int ROW_W   = 3;
	localparam int DIMS_W  = 3;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int IDX_W   = 2;
	localparam int CMD_W   = 2;

	localparam logic [DIMS_W-1:0] DIMS_RST = 3'd4;
	localparam logic [DIMS_W-1:0] DIMS_MAX = 3'd4;
	localparam logic [ROW_W-1:0]  ROW_MEAN = 3'd4;

	localparam logic signed [QW-1:0] QMAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [QW-1:0] QMIN = 48'sh8000_0000_0000;
	localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (FRAC - 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_NEWGRP = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
	} alu_rsp_t;

	typedef struct packed {
		logic signed [QW-1:0] val;
		logic                 sat;
	} sat_res_t;

	// round half up at the fraction point, then clamp to 48 bits
	function automatic sat_res_t round_sat(input logic signed [ACC_W-1:0] x);
		logic [ACC_W-1:0]      b;
		logic [ACC_W-FRAC-1:0] t;
		sat_res_t              r;
		b = x + RND_BIAS;
		t = b[ACC_W-1:FRAC];
		if (t[ACC_W-FRAC-1:QW-1] == '0 || t[ACC_W-FRAC-1:QW-1] == '1) begin
			r.val = t[QW-1:0];
			r.sat = 1'b0;
		end else begin
			r.val = t[ACC_W-FRAC-1] ? QMIN : QMAX;
			r.sat = 1'b1;
		end
		return r;
	endfunction

	// clamp a 50-bit sum to 48 bits
	function automatic sat_res_t sat50(input logic [QW+1:0] x);
		sat_res_t r;
		if (x[QW+1:QW-1] == '0 || x[QW+1:QW-1] == '1) begin
			r.val = x[QW-1:0];
			r.sat = 1'b0;
		end else begin
			r.val = x[QW+1] ? QMIN : QMAX;
			r.sat = 1'b1;
		end
		return r;
	endfunction

	// magnitude with sign applied, widened for accumulation
	function automatic logic signed [ACC_W-1:0] sgn_prod(input logic neg,
		input logic [PROD_W-1:0] m);
		logic [ACC_W-1:0] w;
		w = {2'b00, m};
		return neg ? -w : w;
	endfunction

	function automatic logic [QW-1:0] mag48(input logic signed [QW-1:0] v);
		return v[QW-1] ? -v : v;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/rmcu_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface rmcu_in_if;
	import rmcu_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic signed [QW-1:0]      sample_0;
	logic signed [QW-1:0]      sample_1;
	logic signed [QW-1:0]      sample_2;
	logic signed [QW-1:0]      sample_3;

	modport source (output valid, command, sample_0, sample_1, sample_2, sample_3,
		input ready);
	modport sink (input valid, command, sample_0, sample_1, sample_2, sample_3,
		output ready);
endinterface

interface rmcu_out_if;
	import rmcu_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [ROW_W-1:0]          row_index;
	logic signed [QW-1:0]      value_0;
	logic signed [QW-1:0]      value_1;
	logic signed [QW-1:0]      value_2;
	logic signed [QW-1:0]      value_3;
	logic                      saturated;
	logic                      last;

	modport source (output valid, row_index, value_0, value_1, value_2, value_3,
		saturated, last, input ready);
	modport sink (input valid, row_index, value_0, value_1, value_2, value_3,
		saturated, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/rmcu_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmcu_alu (
	input  wire                          clk,
	input  wire                          arst_n,
	input  rmcu_pkg::alu_req_t           req,
	input  wire [rmcu_pkg::PROD_W-1:0]   opa,
	input  wire [rmcu_pkg::MAG_W-1:0]    opb,
	output rmcu_pkg::alu_rsp_t           rsp,
	output logic [rmcu_pkg::PROD_W-1:0]  res
);
	import rmcu_pkg::*;

	typedef enum logic [1:0] {
		A_IDLE,
		A_RUN,
		A_ROUND
	} alu_st_t;

	alu_st_t          st_q;
	alu_op_t          op_q;
	logic [6:0]       cnt_q;
	logic             done_q;
	logic [6:0]       cnt_last;

	logic [MAG_W-1:0] a_q;
	logic [MAG_W-1:0] b_q;
	logic [NUM_W-1:0] num_q;
	logic [QW-1:0]    den_q;
	logic [QW-1:0]    rem_q;
	logic [RAD_W-1:0] rad_q;
	logic [QW-1:0]    root_q;
	logic [QW+1:0]    srem_q;
	logic [PROD_W-1:0] res_q;

	logic [31:0]       a_sel;
	logic [31:0]       b_sel;
	logic [63:0]       pp;
	logic [PROD_W-1:0] pp_sh;
	logic [QW:0]       rem_s;
	logic [QW+3:0]     r2;
	logic [QW+3:0]     trial;

	// last step index per operation
	always_comb begin
		unique case (op_q)
			ALU_MUL:  cnt_last = 7'd3;
			ALU_DIV:  cnt_last = 7'(NUM_W - 1);
			ALU_SQRT: cnt_last = 7'(RAD_W / 2 - 1);
			default:  cnt_last = 7'd0;
		endcase
	end

	// one 32x32 partial product per step
	always_comb begin
		a_sel = cnt_q[1] ? 32'(a_q[MAG_W-1:32]) : a_q[31:0];
		b_sel = cnt_q[0] ? 32'(b_q[MAG_W-1:32]) : b_q[31:0];
		pp    = a_sel * b_sel;
		pp_sh = PROD_W'(pp) << (7'(cnt_q[1]) * 7'd32 + 7'(cnt_q[0]) * 7'd32);
		rem_s = {rem_q, num_q[NUM_W-1]};
		r2    = {srem_q, rad_q[RAD_W-1:RAD_W-2]};
		trial = {2'b00, root_q, 2'b01};
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			op_q   <= ALU_MUL;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						cnt_q <= '0;
						st_q  <= A_RUN;
					end
				end
				A_RUN: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == cnt_last) st_q <= A_ROUND;
				end
				A_ROUND: begin
					done_q <= 1'b1;
					st_q   <= A_IDLE;
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	// shared datapath: multiply, restoring divide, digit-by-digit root
	always_ff @(posedge clk) begin
		if (st_q == A_IDLE && req.start) begin
			a_q    <= opa[MAG_W-1:0];
			b_q    <= opb;
			num_q  <= opa[NUM_W-1:0];
			den_q  <= opb[QW-1:0];
			rem_q  <= '0;
			rad_q  <= opa[RAD_W-1:0];
			root_q <= '0;
			srem_q <= '0;
			res_q  <= '0;
		end else if (st_q == A_RUN) begin
			unique case (op_q)
				ALU_MUL: res_q <= res_q + pp_sh;
				ALU_DIV: begin
					num_q <= num_q << 1;
					if (rem_s >= {1'b0, den_q}) begin
						rem_q <= QW'(rem_s - {1'b0, den_q});
						res_q <= {res_q[PROD_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_s[QW-1:0];
						res_q <= {res_q[PROD_W-2:0], 1'b0};
					end
				end
				ALU_SQRT: begin
					rad_q <= rad_q << 2;
					if (r2 >= trial) begin
						srem_q <= (QW+2)'(r2 - trial);
						root_q <= {root_q[QW-2:0], 1'b1};
					end else begin
						srem_q <= r2[QW+1:0];
						root_q <= {root_q[QW-2:0], 1'b0};
					end
				end
				default: ;
			endcase
		end else if (st_q == A_ROUND) begin
			unique case (op_q)
				ALU_DIV: begin
					if (rem_q >= den_q - rem_q) res_q <= res_q + PROD_W'(1);
				end
				ALU_SQRT: begin
					res_q <= PROD_W'(root_q) + PROD_W'(srem_q > {2'b00, root_q});
				end
				default: ;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign res      = res_q;

endmodule

`default_nettype wire

/* rtl/core/running_mean_cholesky_update_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake      payload
// in_ch     in   valid/ready    command, sample_0..3
// out_ch    out  valid/ready    row_index, value_0..3, saturated, last
// apb       in   psel/penable   paddr, pwdata -> dims_in_use (prdata returns it)
//
// an add request runs on one shared multiply/divide/root unit; with four coordinates in use
// and every row rotated, its work is set mostly by the 80-step divider (thirteen divides);
// each shared-unit operation is started, runs its steps and then a rounding step
// new subgroup and clear requests are handled in the idle state; a request is taken only when idle
// each result row sits in an output register until taken;
// a stalled sink holds the unit
// reset clears mean, count and factor and sets dims_in_use to four

module running_mean_cholesky_update_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	rmcu_in_if.sink                          in_ch,
	rmcu_out_if.source                       out_ch,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire [rmcu_pkg::PADDR_W-1:0]      paddr,
	input  wire [rmcu_pkg::PDATA_W-1:0]      pwdata,
	output logic [rmcu_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);
	import rmcu_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE,
		S_FDIV,
		S_FSQRT,
		S_MDIV,
		S_WMUL,
		S_RCHK,
		S_RSQ1,
		S_RSQ2,
		S_RSQRT,
		S_RDIVC,
		S_RDIVS,
		S_RJ,
		S_RM1,
		S_RM2,
		S_RM3,
		S_RM4,
		S_EMIT
	} st_t;

	st_t                  st_q;
	logic                 busy_q;
	logic [ROW_W-1:0]     k_q;
	logic [ROW_W-1:0]     j_q;
	logic                 sat_q;
	logic [DIMS_W-1:0]    dims_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [QW-1:0] mean_q [DIM];
	logic signed [QW-1:0] chol_q [DIM][DIM];
	logic signed [QW-1:0] w_q    [DIM];

	logic                 ovalid_q;
	logic [ROW_W-1:0]     orow_q;
	logic signed [QW-1:0] oval_q [DIM];
	logic                 olast_q;

	logic signed [QW-1:0] x_q [DIM];
	logic signed [ACC_W-1:0] acc_q;
	logic [FRAC:0]        f_q;
	logic signed [QW:0]   d_q;
	logic [QW-1:0]        hyp_q;
	logic                 rneg_q;
	logic [FRAC:0]        c_q;
	logic                 cneg_q;
	logic [FRAC:0]        s_q;
	logic                 sneg_q;
	logic signed [QW-1:0] tmp_q;

	logic [DIMS_W-1:0]    p_eff;
	logic                 cfg_wr;
	logic                 head;
	logic [IDX_W-1:0]     ridx;
	logic signed [QW-1:0] chol_rd;
	logic signed [QW-1:0] w_rd;
	logic [QW-1:0]        chol_mag;
	logic [QW-1:0]        w_mag;
	logic signed [QW:0]   d_c;
	logic [MAG_W-1:0]     d_mag;
	logic [MAG_W-1:0]     dq_mag;
	logic [CNT_W:0]       n1;
	logic [QW+1:0]        mean_sum;
	sat_res_t             mean_new;
	logic                 op_state;
	alu_op_t              op_c;
	logic [PROD_W-1:0]    opa_c;
	logic [MAG_W-1:0]     opb_c;
	logic                 mneg;
	logic signed [ACC_W-1:0] sp;
	logic signed [ACC_W-1:0] rnd_in;
	sat_res_t             rnd;
	logic                 hyp_ovf;
	logic [QW-1:0]        hyp_c;
	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;
	logic [PROD_W-1:0]    alu_res;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == 1'b0);
	assign prdata = PDATA_W'(dims_q);

	always_comb begin
		if (dims_q == '0) p_eff = 3'd1;
		else if (dims_q > DIMS_MAX) p_eff = DIMS_MAX;
		else p_eff = dims_q;
	end

	// operand reads: row head uses the diagonal index, the inner loop uses column j
	always_comb begin
		head     = (st_q == S_RCHK) || (st_q == S_RSQ1) || (st_q == S_RSQ2) ||
			(st_q == S_RSQRT) || (st_q == S_RDIVC) || (st_q == S_RDIVS);
		ridx     = head ? k_q[IDX_W-1:0] : j_q[IDX_W-1:0];
		chol_rd  = chol_q[k_q[IDX_W-1:0]][ridx];
		w_rd     = w_q[ridx];
		chol_mag = mag48(chol_rd);
		w_mag    = mag48(w_rd);
		d_c      = {x_q[j_q[IDX_W-1:0]][QW-1], x_q[j_q[IDX_W-1:0]]} -
			{mean_q[j_q[IDX_W-1:0]][QW-1], mean_q[j_q[IDX_W-1:0]]};
		d_mag    = d_c[QW] ? MAG_W'(-d_c) : MAG_W'(d_c);
		dq_mag   = d_q[QW] ? MAG_W'(-d_q) : MAG_W'(d_q);
		n1       = {1'b0, cnt_q} + (CNT_W+1)'(1);
		mean_sum = {{2{mean_q[j_q[IDX_W-1:0]][QW-1]}}, mean_q[j_q[IDX_W-1:0]]} +
			(d_c[QW] ? -(QW+2)'(alu_res[MAG_W-1:0]) : (QW+2)'(alu_res[MAG_W-1:0]));
		mean_new = sat50(mean_sum);
		hyp_ovf  = (alu_res[PROD_W-1:QW-1] != '0);
		hyp_c    = hyp_ovf ? QMAX : alu_res[QW-1:0];
	end

	// shared unit requests per state
	always_comb begin
		op_state = 1'b1;
		op_c     = ALU_MUL;
		opa_c    = '0;
		opb_c    = '0;
		mneg     = 1'b0;
		unique case (st_q)
			S_FDIV: begin
				op_c  = ALU_DIV;
				opa_c = PROD_W'({cnt_q, 64'd0});
				opb_c = MAG_W'(n1);
			end
			S_FSQRT: begin
				op_c  = ALU_SQRT;
				opa_c = acc_q[PROD_W-1:0];
			end
			S_MDIV: begin
				op_c  = ALU_DIV;
				opa_c = PROD_W'(d_mag);
				opb_c = MAG_W'(n1);
			end
			S_WMUL: begin
				opa_c = PROD_W'(f_q);
				opb_c = dq_mag;
				mneg  = d_q[QW];
			end
			S_RSQ1: begin
				opa_c = PROD_W'(chol_mag);
				opb_c = MAG_W'(chol_mag);
			end
			S_RSQ2: begin
				opa_c = PROD_W'(w_mag);
				opb_c = MAG_W'(w_mag);
			end
			S_RSQRT: begin
				op_c  = ALU_SQRT;
				opa_c = acc_q[PROD_W-1:0];
			end
			S_RDIVC: begin
				op_c  = ALU_DIV;
				opa_c = PROD_W'({chol_mag, 32'd0});
				opb_c = MAG_W'(hyp_q);
			end
			S_RDIVS: begin
				op_c  = ALU_DIV;
				opa_c = PROD_W'({w_mag, 32'd0});
				opb_c = MAG_W'(hyp_q);
			end
			S_RM1: begin
				opa_c = PROD_W'(c_q);
				opb_c = MAG_W'(chol_mag);
				mneg  = cneg_q ^ chol_rd[QW-1];
			end
			S_RM2: begin
				opa_c = PROD_W'(s_q);
				opb_c = MAG_W'(w_mag);
				mneg  = sneg_q ^ w_rd[QW-1];
			end
			S_RM3: begin
				opa_c = PROD_W'(c_q);
				opb_c = MAG_W'(w_mag);
				mneg  = cneg_q ^ w_rd[QW-1];
			end
			S_RM4: begin
				opa_c = PROD_W'(s_q);
				opb_c = MAG_W'(chol_mag);
				mneg  = sneg_q ^ chol_rd[QW-1];
			end
			default: op_state = 1'b0;
		endcase
		alu_req.start = op_state && !busy_q;
		alu_req.op    = op_c;
	end

	// signed product and the single rounding point
	always_comb begin
		sp = sgn_prod(mneg, alu_res);
		unique case (st_q)
			S_RM2:   rnd_in = acc_q + sp;
			S_RM4:   rnd_in = acc_q - sp;
			default: rnd_in = sp;
		endcase
		rnd = round_sat(rnd_in);
	end

	rmcu_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.opa    (opa_c),
		.opb    (opb_c),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

	// sequencer, state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			busy_q   <= 1'b0;
			k_q      <= '0;
			j_q      <= '0;
			sat_q    <= 1'b0;
			dims_q   <= DIMS_RST;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
			orow_q   <= '0;
			olast_q  <= 1'b0;
			for (int r = 0; r < DIM; r++) begin
				mean_q[r] <= '0;
				w_q[r]    <= '0;
				oval_q[r] <= '0;
				for (int c = 0; c < DIM; c++) chol_q[r][c] <= '0;
			end
		end else begin
			if (cfg_wr) dims_q <= pwdata[DIMS_W-1:0];
			if (alu_req.start) busy_q <= 1'b1;
			else if (alu_rsp.done) busy_q <= 1'b0;

			unique case (st_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						unique case (cmd_t'(in_ch.command))
							CMD_ADD: begin
								sat_q <= 1'b0;
								j_q   <= '0;
								st_q  <= S_FDIV;
							end
							CMD_NEWGRP: begin
								cnt_q <= '0;
								for (int r = 0; r < DIM; r++) mean_q[r] <= '0;
							end
							CMD_CLEAR: begin
								cnt_q <= '0;
								for (int r = 0; r < DIM; r++) begin
									mean_q[r] <= '0;
									for (int c = 0; c < DIM; c++) chol_q[r][c] <= '0;
								end
							end
							CMD_NOP: ;
						endcase
					end
				end
				S_FDIV:  if (alu_rsp.done) st_q <= S_FSQRT;
				S_FSQRT: if (alu_rsp.done) st_q <= S_MDIV;
				S_MDIV: begin
					if (alu_rsp.done) begin
						mean_q[j_q[IDX_W-1:0]] <= mean_new.val;
						sat_q <= sat_q | mean_new.sat;
						st_q  <= S_WMUL;
					end
				end
				S_WMUL: begin
					if (alu_rsp.done) begin
						w_q[j_q[IDX_W-1:0]] <= rnd.val;
						sat_q <= sat_q | rnd.sat;
						if (j_q == p_eff - 3'd1) begin
							if (!(&cnt_q)) cnt_q <= cnt_q + CNT_W'(1);
							k_q  <= '0;
							st_q <= S_RCHK;
						end else begin
							j_q  <= j_q + 3'd1;
							st_q <= S_MDIV;
						end
					end
				end
				S_RCHK: begin
					if (k_q >= p_eff) begin
						k_q  <= '0;
						st_q <= S_EMIT;
					end else if (w_rd == '0) begin
						k_q <= k_q + 3'd1;
					end else begin
						st_q <= S_RSQ1;
					end
				end
				S_RSQ1: if (alu_rsp.done) st_q <= S_RSQ2;
				S_RSQ2: if (alu_rsp.done) st_q <= S_RSQRT;
				S_RSQRT: begin
					if (alu_rsp.done) begin
						sat_q <= sat_q | hyp_ovf;
						st_q  <= S_RDIVC;
					end
				end
				S_RDIVC: if (alu_rsp.done) st_q <= S_RDIVS;
				S_RDIVS: begin
					if (alu_rsp.done) begin
						chol_q[k_q[IDX_W-1:0]][k_q[IDX_W-1:0]] <= rneg_q ? -hyp_q : hyp_q;
						j_q  <= k_q + 3'd1;
						st_q <= S_RJ;
					end
				end
				S_RJ: begin
					if (j_q >= p_eff) begin
						k_q  <= k_q + 3'd1;
						st_q <= S_RCHK;
					end else begin
						st_q <= S_RM1;
					end
				end
				S_RM1: if (alu_rsp.done) st_q <= S_RM2;
				S_RM2: begin
					if (alu_rsp.done) begin
						sat_q <= sat_q | rnd.sat;
						st_q  <= S_RM3;
					end
				end
				S_RM3: if (alu_rsp.done) st_q <= S_RM4;
				S_RM4: begin
					if (alu_rsp.done) begin
						w_q[j_q[IDX_W-1:0]] <= rnd.val;
						chol_q[k_q[IDX_W-1:0]][j_q[IDX_W-1:0]] <= tmp_q;
						sat_q <= sat_q | rnd.sat;
						j_q   <= j_q + 3'd1;
						st_q  <= S_RJ;
					end
				end
				S_EMIT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						olast_q  <= (k_q == p_eff);
						orow_q   <= (k_q == p_eff) ? ROW_MEAN : k_q;
						for (int c = 0; c < DIM; c++) begin
							if (3'(c) >= p_eff) oval_q[c] <= '0;
							else if (k_q == p_eff) oval_q[c] <= mean_q[c];
							else oval_q[c] <= chol_q[k_q[IDX_W-1:0]][c];
						end
					end else if (out_ch.ready) begin
						ovalid_q <= 1'b0;
						if (olast_q) st_q <= S_IDLE;
						else k_q <= k_q + 3'd1;
					end
				end
			endcase
		end
	end

	// working registers loaded from the input samples and the shared unit
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && in_ch.valid) begin
			x_q[0] <= in_ch.sample_0;
			x_q[1] <= in_ch.sample_1;
			x_q[2] <= in_ch.sample_2;
			x_q[3] <= in_ch.sample_3;
		end
		if (alu_rsp.done) begin
			unique case (st_q)
				S_FDIV:  acc_q <= ACC_W'(alu_res);
				S_FSQRT: f_q   <= alu_res[FRAC:0];
				S_MDIV:  d_q   <= d_c;
				S_RSQ1:  acc_q <= sp;
				S_RSQ2:  acc_q <= acc_q + sp;
				S_RSQRT: begin
					hyp_q  <= hyp_c;
					rneg_q <= (chol_mag > w_mag) ? chol_rd[QW-1] : w_rd[QW-1];
				end
				S_RDIVC: begin
					c_q    <= alu_res[FRAC:0];
					cneg_q <= chol_rd[QW-1] != rneg_q;
				end
				S_RDIVS: begin
					s_q    <= alu_res[FRAC:0];
					sneg_q <= w_rd[QW-1] != rneg_q;
				end
				S_RM1:   acc_q <= sp;
				S_RM2:   tmp_q <= rnd.val;
				S_RM3:   acc_q <= sp;
				default: ;
			endcase
		end
	end

	// channel outputs
	assign in_ch.ready      = (st_q == S_IDLE);
	assign out_ch.valid     = ovalid_q;
	assign out_ch.row_index = orow_q;
	assign out_ch.value_0   = oval_q[0];
	assign out_ch.value_1   = oval_q[1];
	assign out_ch.value_2   = oval_q[2];
	assign out_ch.value_3   = oval_q[3];
	assign out_ch.saturated = sat_q;
	assign out_ch.last      = olast_q;

`ifndef SYNTHESIS
	// no new request is taken while a result row is pending
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("request taken with a result pending");

	// the final row of a run is the mean row
	a_last_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.last) |-> (out_ch.row_index == ROW_MEAN))
		else $error("last row is not the mean row");

	// factor rows stay within the coordinates in use
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.last) |-> (out_ch.row_index < p_eff))
		else $error("factor row out of range");

	// the shared unit only finishes work that was issued
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> busy_q)
		else $error("shared unit done without a pending operation");
`endif

endmodule

`default_nettype wire
